// ===== design/parity_union_find_checker_top_assert.svh =====
// ---------------------------------------------------------------------------
// Parity union-find checker assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef PARITY_UNION_FIND_CHECKER_TOP_ASSERT_SVH
`define PARITY_UNION_FIND_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define PUFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PUFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pufc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parity union-find checker package
// Store geometry, microcode word layout and the control program.
// ---------------------------------------------------------------------------
package pufc_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int STORE_DEPTH = 2 * MAX_NODES + 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NODE_W      = 11;
  localparam int PC_W        = 5;
  localparam int CNT_W       = 32;

  // opcodes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_IDLE  = 3'd1;
  localparam logic [2:0] OP_CALL  = 3'd2;
  localparam logic [2:0] OP_WALK  = 3'd3;
  localparam logic [2:0] OP_COMP  = 3'd4;
  localparam logic [2:0] OP_LINK  = 3'd5;
  localparam logic [2:0] OP_CHECK = 3'd6;
  localparam logic [2:0] OP_DONE  = 3'd7;

  // operand selects
  localparam logic [2:0] OPD_U  = 3'd0;
  localparam logic [2:0] OPD_V  = 3'd1;
  localparam logic [2:0] OPD_UO = 3'd2;
  localparam logic [2:0] OPD_VO = 3'd3;
  localparam logic [2:0] OPD_PA = 3'd4;
  localparam logic [2:0] OPD_PB = 3'd5;
  localparam logic [2:0] OPD_PC = 3'd6;

  // root destinations
  localparam logic DST_A = 1'b0;
  localparam logic DST_B = 1'b1;

  // program addresses
  localparam logic [PC_W-1:0] PC_CLEAR = 5'd0;
  localparam logic [PC_W-1:0] PC_IDLE  = 5'd1;
  localparam logic [PC_W-1:0] PC_START = 5'd2;
  localparam logic [PC_W-1:0] PC_DONE  = 5'd14;
  localparam logic [PC_W-1:0] PC_WALK  = 5'd15;
  localparam logic [PC_W-1:0] PC_COMP  = 5'd16;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      opd;
    logic            dst;
    logic [PC_W-1:0] nxt;
    logic [PC_W-1:0] alt;
  } ucode_t;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_IDLE, opd: OPD_U, dst: DST_A, nxt: PC_IDLE, alt: PC_IDLE};
    case (pc)
      5'd0:  w = '{op: OP_CLEAR, opd: OPD_U,  dst: DST_A, nxt: PC_IDLE,  alt: PC_IDLE};
      5'd1:  w = '{op: OP_IDLE,  opd: OPD_U,  dst: DST_A, nxt: PC_START, alt: PC_DONE};
      5'd2:  w = '{op: OP_CALL,  opd: OPD_PA, dst: DST_A, nxt: PC_WALK,  alt: PC_IDLE};
      5'd3:  w = '{op: OP_CALL,  opd: OPD_PB, dst: DST_B, nxt: PC_WALK,  alt: PC_IDLE};
      5'd4:  w = '{op: OP_LINK,  opd: OPD_U,  dst: DST_A, nxt: 5'd5,     alt: PC_IDLE};
      5'd5:  w = '{op: OP_CALL,  opd: OPD_PC, dst: DST_A, nxt: PC_WALK,  alt: PC_IDLE};
      5'd6:  w = '{op: OP_CALL,  opd: OPD_VO, dst: DST_B, nxt: PC_WALK,  alt: PC_IDLE};
      5'd7:  w = '{op: OP_LINK,  opd: OPD_U,  dst: DST_A, nxt: 5'd8,     alt: PC_IDLE};
      5'd8:  w = '{op: OP_CALL,  opd: OPD_U,  dst: DST_A, nxt: PC_WALK,  alt: PC_IDLE};
      5'd9:  w = '{op: OP_CALL,  opd: OPD_UO, dst: DST_B, nxt: PC_WALK,  alt: PC_IDLE};
      5'd10: w = '{op: OP_CHECK, opd: OPD_U,  dst: DST_A, nxt: 5'd11,    alt: PC_IDLE};
      5'd11: w = '{op: OP_CALL,  opd: OPD_V,  dst: DST_A, nxt: PC_WALK,  alt: PC_IDLE};
      5'd12: w = '{op: OP_CALL,  opd: OPD_VO, dst: DST_B, nxt: PC_WALK,  alt: PC_IDLE};
      5'd13: w = '{op: OP_CHECK, opd: OPD_U,  dst: DST_A, nxt: PC_DONE,  alt: PC_IDLE};
      5'd14: w = '{op: OP_DONE,  opd: OPD_U,  dst: DST_A, nxt: PC_IDLE,  alt: PC_IDLE};
      5'd15: w = '{op: OP_WALK,  opd: OPD_U,  dst: DST_A, nxt: PC_COMP,  alt: PC_IDLE};
      5'd16: w = '{op: OP_COMP,  opd: OPD_U,  dst: DST_A, nxt: PC_IDLE,  alt: PC_IDLE};
      default: w = '{op: OP_IDLE, opd: OPD_U, dst: DST_A, nxt: PC_IDLE, alt: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/parity_union_find_checker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parity union-find checker
// Microcoded union-find over a doubled parent store; one result per request.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 2050-entry parent store to identity, one
// entry a cycle, and takes no request until the sweep ends. Each request then
// runs a fixed program of eight finds, two links and two checks on one memory
// read port and one write port. Besides the finds, it steps through request
// capture, the two links, the two checks and the result. Each find makes a
// call, follows each parent up to the root and confirms the root; it then
// compresses each node on the path below the root to point at the root. A
// request after a conflict skips the program and goes straight to the result
// step. Either kind of request stalls at its result step for as long as a
// previous result still waits unread in the result register. The result
// register lets the next request enter while a result waits.
`include "parity_union_find_checker_top_assert.svh"

module parity_union_find_checker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pufc_pkg::NODE_W-1:0] cfg_data,   // node_count
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // left_point[10:0], right_point[20:11]
  input  logic                        in_tuser,   // parity
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata   // conflict[0], accepted_count[32:1]
);
  import pufc_pkg::*;

  ucode_t            ctl;
  logic [PC_W-1:0]   pc_r, pc_nxt, ret_r, ret_nxt;
  logic              dst_r, dst_nxt;
  logic [ADDR_W-1:0] x_r, x_nxt, rt_r, rt_nxt;
  logic [ADDR_W-1:0] root_a_r, root_a_nxt, root_b_r, root_b_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] u_r, u_nxt, v_r, v_nxt, uo_r, uo_nxt, vo_r, vo_nxt;
  logic              par_r, par_nxt;
  logic              bad_r, bad_nxt, flag_r, flag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] node_count_r;
  logic              out_valid_r, out_valid_nxt, out_load;
  logic              out_flag_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [ADDR_W-1:0] mem [STORE_DEPTH];
  logic [ADDR_W-1:0] mem_raddr, mem_waddr, mem_wdata, rdata_r;
  logic              mem_we;

  logic [NODE_W-1:0] n_eff, u_in, v_in;
  logic [ADDR_W-1:0] opd_val;
  logic              do_ret;

  assign ctl       = ucode(pc_r);
  assign cfg_ready = 1'b1;
  assign in_tready = (ctl.op == OP_IDLE);

  // clamp the request against the effective node count
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_r > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
    u_in = (in_tdata[10:0] > n_eff) ? n_eff : in_tdata[10:0];
    v_in = ({1'b0, in_tdata[20:11]} + NODE_W'(1) > n_eff) ? n_eff
         : {1'b0, in_tdata[20:11]} + NODE_W'(1);
  end

  always_comb begin
    case (ctl.opd)
      OPD_U:   opd_val = u_r;
      OPD_V:   opd_val = v_r;
      OPD_UO:  opd_val = uo_r;
      OPD_VO:  opd_val = vo_r;
      OPD_PA:  opd_val = par_r ? v_r : u_r;
      OPD_PB:  opd_val = par_r ? uo_r : v_r;
      OPD_PC:  opd_val = par_r ? u_r : uo_r;
      default: opd_val = vo_r;
    endcase
  end

  always_comb begin
    pc_nxt        = pc_r;
    ret_nxt       = ret_r;
    dst_nxt       = dst_r;
    x_nxt         = x_r;
    rt_nxt        = rt_r;
    root_a_nxt    = root_a_r;
    root_b_nxt    = root_b_r;
    clr_nxt       = clr_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    uo_nxt        = uo_r;
    vo_nxt        = vo_r;
    par_nxt       = par_r;
    bad_nxt       = bad_r;
    flag_nxt      = flag_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load      = 1'b0;
    mem_raddr     = x_r;
    mem_we        = 1'b0;
    mem_waddr     = x_r;
    mem_wdata     = rt_r;
    do_ret        = 1'b0;

    case (ctl.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          pc_nxt = ctl.nxt;
        end
      end
      OP_IDLE: begin
        if (in_tvalid) begin
          u_nxt   = ADDR_W'(u_in);
          v_nxt   = ADDR_W'(v_in);
          uo_nxt  = ADDR_W'(u_in) + ADDR_W'(n_eff) + ADDR_W'(1);
          vo_nxt  = ADDR_W'(v_in) + ADDR_W'(n_eff) + ADDR_W'(1);
          par_nxt = in_tuser;
          bad_nxt = 1'b0;
          pc_nxt  = flag_r ? ctl.alt : ctl.nxt;
        end
      end
      OP_CALL: begin
        x_nxt     = opd_val;
        rt_nxt    = opd_val;
        mem_raddr = opd_val;
        ret_nxt   = pc_r + PC_W'(1);
        dst_nxt   = ctl.dst;
        pc_nxt    = ctl.nxt;
      end
      OP_WALK: begin
        if (rdata_r == rt_r) begin
          if (x_r == rt_r) begin
            do_ret = 1'b1;
          end else begin
            mem_raddr = x_r;
            pc_nxt    = ctl.nxt;
          end
        end else begin
          rt_nxt    = rdata_r;
          mem_raddr = rdata_r;
        end
      end
      OP_COMP: begin
        mem_we    = 1'b1;
        mem_waddr = x_r;
        mem_wdata = rt_r;
        if (rdata_r == rt_r) begin
          do_ret = 1'b1;
        end else begin
          x_nxt     = rdata_r;
          mem_raddr = rdata_r;
        end
      end
      OP_LINK: begin
        if (root_a_r != root_b_r) begin
          mem_we    = 1'b1;
          mem_waddr = (root_a_r < root_b_r) ? root_a_r : root_b_r;
          mem_wdata = (root_a_r < root_b_r) ? root_b_r : root_a_r;
        end
        pc_nxt = ctl.nxt;
      end
      OP_CHECK: begin
        bad_nxt = bad_r | (root_a_r == root_b_r);
        pc_nxt  = ctl.nxt;
      end
      OP_DONE: begin
        if (!out_valid_r || out_tready) begin
          if (!flag_r) begin
            if (bad_r) begin
              flag_nxt = 1'b1;
            end else if (cnt_r != '1) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          pc_nxt        = ctl.nxt;
        end
      end
      default: begin
        pc_nxt = PC_IDLE;
      end
    endcase

    if (do_ret) begin
      if (dst_r == DST_B) begin
        root_b_nxt = rt_r;
      end else begin
        root_a_nxt = rt_r;
      end
      pc_nxt = ret_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_CLEAR;
      clr_r        <= '0;
      flag_r       <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_W'(MAX_NODES);
    end else begin
      pc_r        <= pc_nxt;
      clr_r       <= clr_nxt;
      flag_r      <= flag_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    dst_r    <= dst_nxt;
    x_r      <= x_nxt;
    rt_r     <= rt_nxt;
    root_a_r <= root_a_nxt;
    root_b_r <= root_b_nxt;
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    uo_r     <= uo_nxt;
    vo_r     <= vo_nxt;
    par_r    <= par_nxt;
    bad_r    <= bad_nxt;
    if (out_load) begin
      out_flag_r <= flag_nxt;
      out_cnt_r  <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_cnt_r, out_flag_r};

  `PUFC_ASSERT_NEXT(a_flag_sticky, flag_r, flag_r, "conflict flag dropped")
  `PUFC_ASSERT_NEXT(a_cnt_frozen, flag_r, $stable(cnt_r), "count moved after conflict")
  `PUFC_ASSERT_NOW(a_link_upward, mem_we && (ctl.op != OP_CLEAR), mem_wdata > mem_waddr,
    "parent pointer written below its node")
  `PUFC_ASSERT_NEXT(a_one_request, in_tvalid && in_tready, !in_tready,
    "request taken while another runs")

endmodule
